// ===== src/status_led_buzzer_pattern_defines.svh =====
// ----------------------------------------------------------------------------
// Status LED / buzzer pattern: assertion macros
// Shared concurrent assertion forms, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_BUZZER_PATTERN_DEFINES_SVH
`define STATUS_LED_BUZZER_PATTERN_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset
`define SLBP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// Check that a condition never holds outside reset
`define SLBP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`else

`define SLBP_ASSERT(lbl, clk, rst_n, prop)
`define SLBP_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== src/sbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Status LED / buzzer pattern package
// Field widths, status codes, register map and pattern timing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sbp_pkg;

	// Payload widths
	localparam int STATUS_W   = 3;
	localparam int INTERVAL_W = 16;

	// Item kinds
	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_NO_FIX   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FIX      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ARMED    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_LOW_BATT = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ERROR    = 3'd4;

	// Default width of the millisecond time base
	localparam int TIME_BITS_DEF = 32;

	// Configuration port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 2;
	localparam logic [REG_IDX_W-1:0] REG_SLOW  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FAST  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_RAPID = 2'd2;

	localparam logic [INTERVAL_W-1:0] SLOW_RST  = 16'd500;
	localparam logic [INTERVAL_W-1:0] FAST_RST  = 16'd100;
	localparam logic [INTERVAL_W-1:0] RAPID_RST = 16'd50;

	// Phase counters: 1000 ms and 2000 ms cycles
	localparam int PH_SHORT_W = 10;
	localparam int PH_LONG_W  = 11;
	localparam logic [PH_SHORT_W-1:0] SHORT_LAST = 10'd999;
	localparam logic [PH_LONG_W-1:0]  LONG_LAST  = 11'd1999;

	// Armed: double blink windows on the short phase
	localparam logic [PH_SHORT_W-1:0] ARM_ON1_END   = 10'd80;
	localparam logic [PH_SHORT_W-1:0] ARM_ON2_START = 10'd160;
	localparam logic [PH_SHORT_W-1:0] ARM_ON2_END   = 10'd240;

	// Low battery: triple beep windows on the long phase
	localparam logic [PH_LONG_W-1:0] BEEP1_END   = 11'd100;
	localparam logic [PH_LONG_W-1:0] BEEP2_START = 11'd200;
	localparam logic [PH_LONG_W-1:0] BEEP2_END   = 11'd300;
	localparam logic [PH_LONG_W-1:0] BEEP3_START = 11'd400;
	localparam logic [PH_LONG_W-1:0] BEEP3_END   = 11'd500;

	// Blink intervals handed from the register file to the pattern core
	typedef struct packed {
		logic [INTERVAL_W-1:0] slow;
		logic [INTERVAL_W-1:0] fast;
		logic [INTERVAL_W-1:0] rapid;
	} cfg_t;

endpackage

`default_nettype wire

// ===== src/sbp_if.sv =====
// ----------------------------------------------------------------------------
// Status LED / buzzer pattern channels
// Valid/ready channels for command items and drive-level results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbp_cmd_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [sbp_pkg::STATUS_W-1:0] status_code;

	modport source (output valid, output kind, output status_code, input ready);
	modport sink (input valid, input kind, input status_code, output ready);
endinterface

interface sbp_drive_if;
	logic valid;
	logic ready;
	logic led;
	logic buzzer;

	modport source (output valid, output led, output buzzer, input ready);
	modport sink (input valid, input led, input buzzer, output ready);
endinterface

`default_nettype wire

// ===== src/status_led_buzzer_pattern.sv =====
// ----------------------------------------------------------------------------
// Status LED / buzzer pattern generator
// Turns millisecond ticks and status updates into LED and buzzer levels.
// ----------------------------------------------------------------------------
// Usage:
//   cmd   : valid/ready command channel. kind = 0 is a one millisecond tick,
//           kind = 1 sets status_code (0 no fix, 1 fix, 2 armed, 3 low
//           battery, 4 error).
//   drive : valid/ready result channel, one transfer per command with the
//           LED and buzzer levels after that command.
//   APB   : blink intervals in ms at 0x0 (no fix), 0x4 (low battery) and
//           0x8 (error); write only while no command is in flight.
// Path: an accepted command is held in the input register, then its result
//   in the result register.
// Throughput: one command per cycle while drive takes each result; the whole
//   update is one compare of the elapsed time against an interval plus the
//   phase decode, done between the input register and the result register.
// Reset: status no fix, time and phases zero, LED and buzzer off, intervals
//   500/100/50 ms.
// Stall: while drive is held off, the input register still takes one more
//   command, then cmd.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "status_led_buzzer_pattern_defines.svh"

module status_led_buzzer_pattern #(
	parameter int TIME_BITS = sbp_pkg::TIME_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	sbp_cmd_if.sink                             cmd,
	sbp_drive_if.source                         drive,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [sbp_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [sbp_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [sbp_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready
);

	sbp_pkg::cfg_t                cfg;
	logic                         valid_s1;
	logic                         kind_s1;
	logic [sbp_pkg::STATUS_W-1:0] code_s1;
	logic                         adv;
	logic                         proc_en;
	logic                         led_nx, buzzer_nx;
	logic                         out_valid_q, led_q, buzzer_q;

	sbp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage advances whenever the result register is free or being drained
	assign adv       = !out_valid_q || drive.ready;
	assign cmd.ready = !valid_s1 || adv;
	assign proc_en   = valid_s1 && adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			kind_s1 <= cmd.kind;
			code_s1 <= cmd.status_code;
		end
	end

	sbp_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (proc_en),
		.kind        (kind_s1),
		.status_code (code_s1),
		.cfg         (cfg),
		.led_nx      (led_nx),
		.buzzer_nx   (buzzer_nx)
	);

	// Result register: load on a processed item, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc_en) begin
			out_valid_q <= 1'b1;
		end else if (drive.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_en) begin
			led_q    <= led_nx;
			buzzer_q <= buzzer_nx;
		end
	end

	assign drive.valid  = out_valid_q;
	assign drive.led    = led_q;
	assign drive.buzzer = buzzer_q;

	`SLBP_ASSERT(a_ready_when_empty, clk, arst_n, !out_valid_q |-> cmd.ready)
	`SLBP_ASSERT(a_stage_kept, clk, arst_n, valid_s1 && !adv |=> valid_s1)

endmodule

`default_nettype wire

// ===== src/sbp_cfg.sv =====
// ----------------------------------------------------------------------------
// Status LED / buzzer pattern register file
// APB-style access to the three blink interval registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sbp_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [sbp_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [sbp_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [sbp_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready,
	output sbp_pkg::cfg_t                       cfg
);

	logic [sbp_pkg::REG_IDX_W-1:0]  reg_idx;
	logic                           wr_en;
	logic [sbp_pkg::INTERVAL_W-1:0] wdata;
	sbp_pkg::cfg_t                  cfg_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[sbp_pkg::APB_ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign wdata   = pwdata[sbp_pkg::INTERVAL_W-1:0];

	// Write the addressed interval; other addresses drop the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slow  <= sbp_pkg::SLOW_RST;
			cfg_q.fast  <= sbp_pkg::FAST_RST;
			cfg_q.rapid <= sbp_pkg::RAPID_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				sbp_pkg::REG_SLOW:  cfg_q.slow  <= wdata;
				sbp_pkg::REG_FAST:  cfg_q.fast  <= wdata;
				sbp_pkg::REG_RAPID: cfg_q.rapid <= wdata;
				default: ;
			endcase
		end
	end

	// Read back the addressed interval
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			sbp_pkg::REG_SLOW:  prdata = {{(sbp_pkg::APB_DATA_W-sbp_pkg::INTERVAL_W){1'b0}},
				cfg_q.slow};
			sbp_pkg::REG_FAST:  prdata = {{(sbp_pkg::APB_DATA_W-sbp_pkg::INTERVAL_W){1'b0}},
				cfg_q.fast};
			sbp_pkg::REG_RAPID: prdata = {{(sbp_pkg::APB_DATA_W-sbp_pkg::INTERVAL_W){1'b0}},
				cfg_q.rapid};
			default:            prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== src/sbp_core.sv =====
// ----------------------------------------------------------------------------
// Status LED / buzzer pattern core
// Holds status, time base and phases; computes the drive levels per item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "status_led_buzzer_pattern_defines.svh"

module sbp_core #(
	parameter int TIME_BITS = sbp_pkg::TIME_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         kind,
	input  wire logic [sbp_pkg::STATUS_W-1:0] status_code,
	input  wire sbp_pkg::cfg_t                cfg,
	output logic                              led_nx,
	output logic                              buzzer_nx
);

	logic [sbp_pkg::STATUS_W-1:0]   status_q, status_nx;
	logic [TIME_BITS-1:0]           time_q, time_nx, last_q, last_nx, elapsed;
	logic                           flag_q, flag_nx;
	logic [sbp_pkg::PH_SHORT_W-1:0] ph_short_q, ph_short_nx, ph_short_inc;
	logic [sbp_pkg::PH_LONG_W-1:0]  ph_long_q, ph_long_nx, ph_long_inc;
	logic                           led_q, buzzer_q;
	logic [sbp_pkg::INTERVAL_W-1:0] interval;
	logic                           toggle_hit;
	logic                           arm_on, beep_on;

	// Advance time base and wrap the phase counters
	assign time_nx      = time_q + TIME_BITS'(1);
	assign ph_short_inc = (ph_short_q == sbp_pkg::SHORT_LAST) ? '0 :
		ph_short_q + sbp_pkg::PH_SHORT_W'(1);
	assign ph_long_inc  = (ph_long_q == sbp_pkg::LONG_LAST) ? '0 :
		ph_long_q + sbp_pkg::PH_LONG_W'(1);

	// Pick the toggle interval of the current status
	always_comb begin
		unique case (status_q)
			sbp_pkg::ST_LOW_BATT: interval = cfg.fast;
			sbp_pkg::ST_ERROR:    interval = cfg.rapid;
			default:              interval = cfg.slow;
		endcase
	end

	assign elapsed    = time_nx - last_q;
	assign toggle_hit = elapsed >= TIME_BITS'(interval);

	// Fixed pattern windows
	assign arm_on  = (ph_short_inc < sbp_pkg::ARM_ON1_END) ||
		((ph_short_inc >= sbp_pkg::ARM_ON2_START) && (ph_short_inc < sbp_pkg::ARM_ON2_END));
	assign beep_on = (ph_long_inc < sbp_pkg::BEEP1_END) ||
		((ph_long_inc >= sbp_pkg::BEEP2_START) && (ph_long_inc < sbp_pkg::BEEP2_END)) ||
		((ph_long_inc >= sbp_pkg::BEEP3_START) && (ph_long_inc < sbp_pkg::BEEP3_END));

	// Next state for one item
	always_comb begin
		status_nx   = status_q;
		last_nx     = last_q;
		flag_nx     = flag_q;
		ph_short_nx = ph_short_q;
		ph_long_nx  = ph_long_q;
		led_nx      = led_q;
		buzzer_nx   = buzzer_q;
		if (kind == sbp_pkg::KIND_TICK) begin
			ph_short_nx = ph_short_inc;
			ph_long_nx  = ph_long_inc;
			unique case (status_q) inside
				sbp_pkg::ST_NO_FIX, sbp_pkg::ST_LOW_BATT, sbp_pkg::ST_ERROR: begin
					if (toggle_hit) begin
						last_nx = time_nx;
						flag_nx = ~flag_q;
						led_nx  = ~flag_q;
					end
					if (status_q == sbp_pkg::ST_NO_FIX) begin
						buzzer_nx = 1'b0;
					end else if (status_q == sbp_pkg::ST_LOW_BATT) begin
						buzzer_nx = beep_on;
					end else begin
						buzzer_nx = 1'b1;
					end
				end
				sbp_pkg::ST_FIX: begin
					led_nx    = 1'b1;
					buzzer_nx = 1'b0;
				end
				sbp_pkg::ST_ARMED: begin
					led_nx    = arm_on;
					buzzer_nx = 1'b0;
				end
				default: ;
			endcase
		end else if (status_code != status_q) begin
			status_nx = status_code;
			buzzer_nx = 1'b0;
		end
	end

	// Commit state when the item is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q   <= sbp_pkg::ST_NO_FIX;
			time_q     <= '0;
			last_q     <= '0;
			flag_q     <= 1'b0;
			ph_short_q <= '0;
			ph_long_q  <= '0;
			led_q      <= 1'b0;
			buzzer_q   <= 1'b0;
		end else if (en) begin
			status_q   <= status_nx;
			if (kind == sbp_pkg::KIND_TICK) begin
				time_q <= time_nx;
			end
			last_q     <= last_nx;
			flag_q     <= flag_nx;
			ph_short_q <= ph_short_nx;
			ph_long_q  <= ph_long_nx;
			led_q      <= led_nx;
			buzzer_q   <= buzzer_nx;
		end
	end

	`SLBP_ASSERT(a_status_change_mutes, clk, arst_n,
		en && (kind == sbp_pkg::KIND_STATUS) && (status_code != status_q) |=> !buzzer_q)
	`SLBP_ASSERT(a_error_tone, clk, arst_n,
		en && (kind == sbp_pkg::KIND_TICK) && (status_q == sbp_pkg::ST_ERROR) |=> buzzer_q)
	`SLBP_ASSERT_NEVER(a_phase_range, clk, arst_n,
		(ph_short_q > sbp_pkg::SHORT_LAST) || (ph_long_q > sbp_pkg::LONG_LAST))

endmodule

`default_nettype wire
